>>> rtl/ptd_pkg.sv
// ============================================================================
// ptd_pkg: shared types and constants for the periodic task dispatcher
// Request and status codes, payload structs and the modulo unit result type.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package ptd_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned REQ_W    = 3;
  localparam int unsigned TASK_W   = 3;
  localparam int unsigned DATA_W   = 16;
  localparam int unsigned STATUS_W = 2;

  // Default table depth and the most results one tick may produce.
  localparam int unsigned TASK_COUNT_DEF = 8;
  localparam int unsigned MAX_OUT        = 8;

  // Reset value of the wrap register.
  localparam logic [DATA_W-1:0] TICK_WRAP_RST = 16'hFFFF;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_TICK    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_CREATE  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SUSPEND = 3'd2;
  localparam logic [REQ_W-1:0] REQ_RESUME  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DELETE  = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OCCUPIED   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_HANDLER = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [TASK_W-1:0] task_index;
    logic [DATA_W-1:0] period;
    logic              handler_present;
  } ptd_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                fired;
    logic [TASK_W-1:0]   fired_task;
    logic                last;
  } ptd_out_t;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } ptd_mod_res_t;

endpackage

`default_nettype wire

>>> rtl/ptd_mod_unit.sv
// ============================================================================
// ptd_mod_unit: iterative remainder unit
// Restoring division, one quotient bit per cycle; reports whether the
// remainder is zero, raising done as the last step's remainder is registered.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ptd_mod_unit import ptd_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DATA_W-1:0] dividend_i,
  input  wire logic [DATA_W-1:0] divisor_i,
  output ptd_mod_res_t           res_o
);

  localparam int unsigned StepW = $clog2(DATA_W + 1);

  logic [DATA_W-1:0] rem_q, dvd_q, dsr_q;
  logic [StepW-1:0]  step_q;
  logic              done_q;

  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic [DATA_W-1:0] rem_d;

  // The partial remainder stays below the divisor, so the trial fits one
  // extra bit and a single subtract decides the quotient bit.
  assign trial = {rem_q, dvd_q[DATA_W-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign rem_d = diff[DATA_W] ? trial[DATA_W-1:0] : diff[DATA_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      dvd_q  <= '0;
      dsr_q  <= '0;
      step_q <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      rem_q  <= '0;
      dvd_q  <= dividend_i;
      dsr_q  <= divisor_i;
      step_q <= StepW'(DATA_W);
      done_q <= 1'b0;
    end else if (step_q != '0) begin
      rem_q  <= rem_d;
      dvd_q  <= {dvd_q[DATA_W-2:0], 1'b0};
      step_q <= step_q - StepW'(1);
      done_q <= (step_q == StepW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  assign res_o.done     = done_q;
  assign res_o.rem_zero = (rem_q == '0);

endmodule

`default_nettype wire

>>> rtl/periodic_task_dispatcher_top.sv
// ============================================================================
// periodic_task_dispatcher_top: periodic tick task dispatcher
// Task slot table with create, suspend, resume and delete requests; a tick
// request advances or restarts the counter and reports due tasks in slot order.
// ============================================================================
//
//   Channel   Direction  Handshake            Payload
//   in        input      in_valid/in_ready    ptd_in_t   (one request)
//   out       output     out_valid/out_ready  ptd_out_t  (one result)
//   cfg       input      cfg_we               16-bit tick wrap value
//
// A non-tick request or a wrap tick goes to a staging register when it is
// accepted and on to the output register from the push state. Any other tick
// walks the slots with one shared remainder unit: a slot that is not active
// is read and skipped, an active slot with period zero is read and checked,
// and an active one also waits on the divider; each due task but the last
// goes out through the push state, and a final state stages the last result.
// One item is handled at a time; in_ready is low until its last result is
// in the output register. A stalled output holds the sequencer in S_PUSH.
// Reset clears all slots and the counter and loads the wrap register with
// TICK_WRAP_RST; no period clearing is needed: it is only used for a slot in use.
//
`timescale 1ns / 1ps
`default_nettype none

module periodic_task_dispatcher_top import ptd_pkg::*; #(
  parameter int unsigned TASK_COUNT = TASK_COUNT_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  input  wire ptd_in_t           in_data_i,
  output      logic              out_valid_o,
  input  wire logic              out_ready_i,
  output ptd_out_t               out_data_o,
  input  wire logic              cfg_we_i,
  input  wire logic [DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned IdxW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
  localparam int unsigned CntW = $clog2(MAX_OUT);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_DIV,
    S_NEXT,
    S_FINAL,
    S_PUSH
  } state_e;

  state_e            state_q, ret_q;
  logic [DATA_W-1:0] tick_wrap_q, tick_count_q;
  logic [TASK_COUNT-1:0] in_use_q, resumed_q;
  logic [DATA_W-1:0] period_mem [TASK_COUNT];
  logic [DATA_W-1:0] period_rd_q;
  logic [IdxW-1:0]   idx_q, pend_q;
  logic              have_pend_q;
  logic [CntW-1:0]   cnt_q;
  ptd_out_t          stage_q, out_q;
  logic              out_valid_q;

  logic              accept;
  logic              task_valid;
  logic [IdxW-1:0]   ti;
  logic              create_ok;
  logic [STATUS_W-1:0] req_status;
  logic [DATA_W-1:0] tick_inc;
  logic              mod_start;
  ptd_mod_res_t      mod_res;
  logic              found_last;
  logic              out_push;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign task_valid = (32'(in_data_i.task_index) < TASK_COUNT);
  assign ti         = IdxW'(in_data_i.task_index);
  assign create_ok  = in_data_i.handler_present && task_valid && !in_use_q[ti];
  assign req_status = (in_data_i.req_type != REQ_CREATE) ? ST_OK :
                      !in_data_i.handler_present       ? ST_NO_HANDLER :
                      !create_ok                       ? ST_OCCUPIED : ST_OK;
  assign tick_inc   = tick_count_q + DATA_W'(1);
  assign mod_start  = (state_q == S_CHECK) && (period_rd_q != '0);
  assign found_last = (cnt_q == CntW'(MAX_OUT - 1));
  assign out_push   = (state_q == S_PUSH) && (!out_valid_q || out_ready_i);

  ptd_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (tick_count_q),
    .divisor_i  (period_rd_q),
    .res_o      (mod_res)
  );

  // Period table: written on a successful create, read at the scan index.
  always_ff @(posedge clk_i) begin
    if (accept && (in_data_i.req_type == REQ_CREATE) && create_ok) begin
      period_mem[ti] <= in_data_i.period;
    end
    period_rd_q <= period_mem[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ret_q        <= S_IDLE;
      tick_wrap_q  <= TICK_WRAP_RST;
      tick_count_q <= '0;
      in_use_q     <= '0;
      resumed_q    <= '0;
      idx_q        <= '0;
      pend_q       <= '0;
      have_pend_q  <= 1'b0;
      cnt_q        <= '0;
      stage_q      <= '0;
      out_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tick_wrap_q <= cfg_wdata_i;
      end
      if (out_push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            ret_q <= S_IDLE;
            if (in_data_i.req_type == REQ_TICK) begin
              if (tick_inc == tick_wrap_q) begin
                // Wrap tick: counter restarts and nothing fires.
                tick_count_q <= '0;
                stage_q      <= '{status: ST_OK, fired: 1'b0, fired_task: '0, last: 1'b1};
                state_q      <= S_PUSH;
              end else begin
                tick_count_q <= tick_inc;
                idx_q        <= '0;
                have_pend_q  <= 1'b0;
                cnt_q        <= '0;
                state_q      <= S_READ;
              end
            end else begin
              stage_q <= '{status: req_status, fired: 1'b0, fired_task: '0, last: 1'b1};
              unique case (in_data_i.req_type)
                REQ_CREATE: begin
                  if (create_ok) begin
                    in_use_q[ti]  <= 1'b1;
                    resumed_q[ti] <= 1'b1;
                  end
                end
                REQ_SUSPEND: begin
                  if (task_valid) resumed_q[ti] <= 1'b0;
                end
                REQ_RESUME: begin
                  if (task_valid) resumed_q[ti] <= 1'b1;
                end
                REQ_DELETE: begin
                  if (task_valid) in_use_q[ti] <= 1'b0;
                end
                default: begin
                end
              endcase
              state_q <= S_PUSH;
            end
          end
        end
        S_READ: begin
          state_q <= (in_use_q[idx_q] && resumed_q[idx_q]) ? S_CHECK : S_NEXT;
        end
        S_CHECK: begin
          state_q <= (period_rd_q != '0) ? S_DIV : S_NEXT;
        end
        S_DIV: begin
          if (mod_res.done) begin
            if (mod_res.rem_zero) begin
              // A found task is held back one step so that the final one
              // can carry the last flag.
              if (have_pend_q) begin
                stage_q <= '{status: ST_OK, fired: 1'b1,
                             fired_task: TASK_W'(pend_q), last: 1'b0};
                ret_q   <= found_last ? S_FINAL : S_NEXT;
                state_q <= S_PUSH;
              end else begin
                state_q <= found_last ? S_FINAL : S_NEXT;
              end
              have_pend_q <= 1'b1;
              pend_q      <= idx_q;
              cnt_q       <= cnt_q + CntW'(1);
            end else begin
              state_q <= S_NEXT;
            end
          end
        end
        S_NEXT: begin
          if (idx_q == IdxW'(TASK_COUNT - 1)) begin
            state_q <= S_FINAL;
          end else begin
            idx_q   <= idx_q + IdxW'(1);
            state_q <= S_READ;
          end
        end
        S_FINAL: begin
          stage_q <= '{status: ST_OK, fired: have_pend_q,
                       fired_task: have_pend_q ? TASK_W'(pend_q) : '0, last: 1'b1};
          ret_q   <= S_IDLE;
          state_q <= S_PUSH;
        end
        S_PUSH: begin
          if (out_push) begin
            out_q   <= stage_q;
            state_q <= ret_q;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> rtl/ptd_checker.sv
// ============================================================================
// ptd_checker: port-level checks for the periodic task dispatcher
// Watches the top-level ports and flags result items that break the rules.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ptd_checker import ptd_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire ptd_out_t          out_data_o
);

  // A stalled result item holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output item changed while stalled");

  // Only one item is taken at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted twice in a row");

  // A due-task item always reports status ok.
  a_fired_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.fired |-> out_data_o.status == ST_OK)
    else $error("fired item with nonzero status");

  // An item that names no task is marked last and carries task zero.
  a_nofire_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.fired |-> out_data_o.last && out_data_o.fired_task == '0)
    else $error("non-fired item not last or with a task index");

endmodule

bind periodic_task_dispatcher_top ptd_checker u_ptd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
